>>> rtl/cbm_pkg.sv
// Package for the channel blend block: modes, register indexes, pipeline item.
`default_nettype none
package cbm_pkg;

  typedef enum logic [4:0] {
    MODE_NORMAL        = 5'd0,
    MODE_LIGHTEN       = 5'd1,
    MODE_DARKEN        = 5'd2,
    MODE_MULTIPLY      = 5'd3,
    MODE_AVERAGE       = 5'd4,
    MODE_ADD           = 5'd5,
    MODE_SUBTRACT      = 5'd6,
    MODE_DIFFERENCE    = 5'd7,
    MODE_NEGATION      = 5'd8,
    MODE_SCREEN        = 5'd9,
    MODE_EXCLUSION     = 5'd10,
    MODE_OVERLAY       = 5'd11,
    MODE_SOFT_LIGHT    = 5'd12,
    MODE_HARD_LIGHT    = 5'd13,
    MODE_COLOR_DODGE   = 5'd14,
    MODE_COLOR_BURN    = 5'd15,
    MODE_LINEAR_DODGE  = 5'd16,
    MODE_LINEAR_BURN   = 5'd17,
    MODE_LINEAR_LIGHT  = 5'd18,
    MODE_VIVID_LIGHT   = 5'd19,
    MODE_PIN_LIGHT     = 5'd20,
    MODE_HARD_MIX      = 5'd21,
    MODE_REFLECT       = 5'd22,
    MODE_GLOW          = 5'd23,
    MODE_PHOENIX       = 5'd24,
    MODE_DIVIDE        = 5'd25
  } blend_mode_t;

  typedef enum logic {
    CFG_BLEND_MODE = 1'b0,
    CFG_MASK_ALPHA = 1'b1
  } cfg_index_t;

  localparam int unsigned DIV_STAGES = 4;
  localparam int unsigned STAGES     = 8;

  localparam logic [8:0]  ALPHA_MAX  = 9'd256;
  localparam logic [7:0]  FULL       = 8'd255;
  // x/255 == (x*RECIP_255) >> RECIP_SHIFT for every x below 2^17
  localparam logic [17:0] RECIP_255   = 18'd131587;
  localparam int unsigned RECIP_SHIFT = 25;

  typedef struct packed {
    logic [7:0]  s;
    logic [7:0]  m;
    logic [4:0]  mode;
    logic [8:0]  alpha;
    logic [16:0] prod;
    logic [16:0] num;
    logic [7:0]  den;
    logic        ov;
    logic [8:0]  q255;
    logic [7:0]  t;
    logic [7:0]  p;
    logic        bypass;
    logic        hardmix;
  } item_t;

endpackage
`default_nettype wire

>>> rtl/cbm_divider.sv
// Pipelined restoring divider: 8 quotient bits, two per stage.
`default_nettype none
module cbm_divider (
  input  wire logic                           clk,
  input  wire logic [cbm_pkg::DIV_STAGES-1:0] en,
  input  wire logic [16:0]                    num,
  input  wire logic [7:0]                     den,
  output logic [7:0]                          quot
);

  logic [16:0] rem_q [cbm_pkg::DIV_STAGES];
  logic [7:0]  quo_q [cbm_pkg::DIV_STAGES];
  logic [7:0]  den_q [cbm_pkg::DIV_STAGES];

  for (genvar g = 0; g < cbm_pkg::DIV_STAGES; g++) begin : g_stage
    logic [16:0] rem_src;
    logic [7:0]  quo_src;
    logic [7:0]  den_src;
    logic [16:0] rem_next;
    logic [7:0]  quo_next;

    if (g == 0) begin : g_first
      assign rem_src = num;
      assign quo_src = '0;
      assign den_src = den;
    end else begin : g_rest
      assign rem_src = rem_q[g-1];
      assign quo_src = quo_q[g-1];
      assign den_src = den_q[g-1];
    end

    always_comb begin
      logic [16:0] dv;
      logic [2:0]  sh;
      rem_next = rem_src;
      quo_next = quo_src;
      for (int j = 0; j < 2; j++) begin
        sh = 3'(7 - 2 * g - j);
        dv = {9'd0, den_src} << sh;
        if (rem_next >= dv) begin
          rem_next     = rem_next - dv;
          quo_next[sh] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rem_q[g] <= rem_next;
        quo_q[g] <= quo_next;
        den_q[g] <= den_src;
      end
    end
  end

  assign quot = quo_q[cbm_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

>>> rtl/channel_blend_modes.sv
// Top level of the per-channel layer blend pipeline.
`default_nettype none
// Per-channel layer blend. One item (source and mask channel value) enters per
// clock while in_ready is high; the depth is set mostly by the 4-stage divider
// used by the color dodge, color burn, vivid light, hard mix, reflect, glow and
// divide modes. Stages: operand select and 8x9 multiply, numerator/overflow and
// x/255, four divider stages, mode result, alpha mix into the output register.
// A stalled output holds only full stages with no empty stage after them; the
// rest move on into the bubbles. blend_mode and mask_alpha are written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the pipeline is empty.
module channel_blend_modes (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [8:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] source_value,
  input  wire logic [7:0] mask_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      blended_value
);

  localparam int unsigned N = cbm_pkg::STAGES;

  logic [4:0] blend_mode;
  logic [8:0] mask_alpha;

  always_ff @(posedge clk) begin
    if (rst) begin
      blend_mode <= 5'd0;
      mask_alpha <= 9'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        cbm_pkg::CFG_BLEND_MODE: blend_mode <= cfg_data[4:0];
        cbm_pkg::CFG_MASK_ALPHA: mask_alpha <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [N-1:0] vld;
  logic [N-1:0] en;

  always_comb begin
    en[N-1] = !vld[N-1] || out_ready;
    for (int i = N - 2; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= in_valid;
      for (int i = 1; i < N; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld[N-1];

  cbm_pkg::item_t ra, rb, c1, c2, c3, c4, rf;
  cbm_pkg::item_t ra_next, rb_next, rf_next;
  logic [7:0] ro;
  logic [7:0] ro_next;
  logic [7:0] quot;

  // stage A: operand select and multiply
  always_comb begin
    logic [7:0] s, m, k, kc, sc, mc;
    logic [8:0] ma;
    logic [7:0] mb;
    s  = source_value;
    m  = mask_value;
    sc = cbm_pkg::FULL - s;
    mc = cbm_pkg::FULL - m;
    k  = {1'b0, m[7:1]} + 8'd64;
    kc = cbm_pkg::FULL - k;
    ma = 9'd0;
    mb = 8'd0;
    ra_next       = '0;
    ra_next.s     = s;
    ra_next.m     = m;
    ra_next.mode  = blend_mode;
    ra_next.alpha = (mask_alpha > cbm_pkg::ALPHA_MAX) ? cbm_pkg::ALPHA_MAX : mask_alpha;
    ra_next.den   = 8'd0;
    case (blend_mode)
      cbm_pkg::MODE_MULTIPLY:  begin ma = {1'b0, s}; mb = m; end
      cbm_pkg::MODE_EXCLUSION: begin ma = {s, 1'b0}; mb = m; end
      cbm_pkg::MODE_SCREEN:    begin ma = {1'b0, sc}; mb = mc; end
      cbm_pkg::MODE_OVERLAY: begin
        if (!m[7]) begin ma = {s, 1'b0}; mb = m; end
        else begin ma = {sc, 1'b0}; mb = mc; end
      end
      cbm_pkg::MODE_SOFT_LIGHT: begin
        if (!s[7]) begin ma = {k, 1'b0}; mb = s; end
        else begin ma = {kc, 1'b0}; mb = sc; end
      end
      cbm_pkg::MODE_HARD_LIGHT: begin
        if (!s[7]) begin ma = {m, 1'b0}; mb = s; end
        else begin ma = {mc, 1'b0}; mb = sc; end
      end
      cbm_pkg::MODE_COLOR_DODGE: ra_next.den = mc;
      cbm_pkg::MODE_COLOR_BURN:  ra_next.den = m;
      // burn divides by d, dodge by 255-d
      cbm_pkg::MODE_VIVID_LIGHT,
      cbm_pkg::MODE_HARD_MIX:
        ra_next.den = m[7] ? cbm_pkg::FULL - {m[6:0], 1'b0} : {m[6:0], 1'b0};
      cbm_pkg::MODE_REFLECT: begin ma = {1'b0, s}; mb = s; ra_next.den = mc; end
      cbm_pkg::MODE_GLOW:    begin ma = {1'b0, m}; mb = m; ra_next.den = sc; end
      cbm_pkg::MODE_DIVIDE:  begin ma = {1'b0, s}; mb = cbm_pkg::FULL; ra_next.den = m; end
      default: ;
    endcase
    ra_next.prod = {8'd0, ma} * {9'd0, mb};
  end

  // stage B: numerator, overflow (quotient above 255) and x/255
  always_comb begin
    logic [34:0] rp;
    logic        dodge_like, burn_like;
    rb_next    = ra;
    dodge_like = (ra.mode == cbm_pkg::MODE_COLOR_DODGE) ||
                 (((ra.mode == cbm_pkg::MODE_VIVID_LIGHT) ||
                   (ra.mode == cbm_pkg::MODE_HARD_MIX)) && ra.m[7]);
    burn_like  = (ra.mode == cbm_pkg::MODE_COLOR_BURN) ||
                 (((ra.mode == cbm_pkg::MODE_VIVID_LIGHT) ||
                   (ra.mode == cbm_pkg::MODE_HARD_MIX)) && !ra.m[7]);
    if (dodge_like)     rb_next.num = {1'b0, ra.s, 8'd0};
    else if (burn_like) rb_next.num = {1'b0, cbm_pkg::FULL - ra.s, 8'd0};
    else                rb_next.num = ra.prod;
    rb_next.ov   = rb_next.num >= {1'b0, ra.den, 8'd0};
    rp           = ra.prod * cbm_pkg::RECIP_255;
    rb_next.q255 = rp[cbm_pkg::RECIP_SHIFT +: 9];
  end

  cbm_divider u_div (
    .clk  (clk),
    .en   (en[5:2]),
    .num  (rb.num),
    .den  (rb.den),
    .quot (quot)
  );

  // stage F: mode result t and mix partner p
  always_comb begin
    logic [7:0] s, m, d, mx, mn, qsat, burnv, q8;
    logic [8:0] sum, sd;
    s     = c4.s;
    m     = c4.m;
    d     = {m[6:0], 1'b0};
    mx    = (s > m) ? s : m;
    mn    = (s > m) ? m : s;
    sum   = {1'b0, s} + {1'b0, m};
    sd    = {1'b0, s} + {1'b0, d};
    qsat  = c4.ov ? cbm_pkg::FULL : quot;
    burnv = c4.ov ? 8'd0 : cbm_pkg::FULL - quot;
    q8    = c4.q255[7:0];
    rf_next         = c4;
    rf_next.t       = 8'd0;
    rf_next.p       = m;
    rf_next.bypass  = 1'b0;
    rf_next.hardmix = 1'b0;
    case (c4.mode)
      cbm_pkg::MODE_NORMAL: begin
        rf_next.t = m; rf_next.p = s; rf_next.bypass = (m == 8'd0);
      end
      cbm_pkg::MODE_LIGHTEN:  rf_next.t = mx;
      cbm_pkg::MODE_DARKEN:   rf_next.t = mn;
      cbm_pkg::MODE_MULTIPLY: rf_next.t = q8;
      cbm_pkg::MODE_AVERAGE:  rf_next.t = sum[8:1];
      cbm_pkg::MODE_ADD,
      cbm_pkg::MODE_LINEAR_DODGE: rf_next.t = sum[8] ? cbm_pkg::FULL : sum[7:0];
      cbm_pkg::MODE_SUBTRACT,
      cbm_pkg::MODE_LINEAR_BURN:
        rf_next.t = (sum < 9'd255) ? 8'd0 : 8'(sum - 9'd255);
      cbm_pkg::MODE_DIFFERENCE: rf_next.t = mx - mn;
      cbm_pkg::MODE_NEGATION:
        rf_next.t = (sum > 9'd255) ? 8'(9'd510 - sum) : sum[7:0];
      cbm_pkg::MODE_SCREEN:    rf_next.t = cbm_pkg::FULL - c4.prod[15:8];
      cbm_pkg::MODE_EXCLUSION: rf_next.t = 8'(sum - c4.q255);
      cbm_pkg::MODE_OVERLAY:   rf_next.t = m[7] ? cbm_pkg::FULL - q8 : q8;
      cbm_pkg::MODE_SOFT_LIGHT: rf_next.t = s[7] ? cbm_pkg::FULL - q8 : q8;
      cbm_pkg::MODE_HARD_LIGHT: begin
        rf_next.t = s[7] ? cbm_pkg::FULL - q8 : q8; rf_next.p = s;
      end
      cbm_pkg::MODE_COLOR_DODGE: rf_next.t = qsat;
      cbm_pkg::MODE_COLOR_BURN:  rf_next.t = burnv;
      cbm_pkg::MODE_LINEAR_LIGHT: begin
        rf_next.p = d;
        if (!m[7]) rf_next.t = (sd < 9'd255) ? 8'd0 : 8'(sd - 9'd255);
        else       rf_next.t = sd[8] ? cbm_pkg::FULL : sd[7:0];
      end
      cbm_pkg::MODE_VIVID_LIGHT: begin
        rf_next.p = d; rf_next.t = m[7] ? qsat : burnv;
      end
      cbm_pkg::MODE_HARD_MIX: begin
        rf_next.p = d; rf_next.t = m[7] ? qsat : burnv; rf_next.hardmix = 1'b1;
      end
      cbm_pkg::MODE_PIN_LIGHT: begin
        rf_next.p = d;
        if (!m[7]) rf_next.t = (s < d) ? s : d;
        else       rf_next.t = (s > d) ? s : d;
      end
      cbm_pkg::MODE_REFLECT: rf_next.t = qsat;
      cbm_pkg::MODE_GLOW:    begin rf_next.t = qsat; rf_next.p = s; end
      cbm_pkg::MODE_PHOENIX: rf_next.t = cbm_pkg::FULL - (mx - mn);
      cbm_pkg::MODE_DIVIDE:  rf_next.t = qsat;
      default: begin rf_next.t = s; rf_next.bypass = 1'b1; end
    endcase
  end

  // stage G: alpha*(p-t) + 256*t, then >> 8; bypass passes s, hard mix thresholds
  always_comb begin
    logic signed [9:0]  diff;
    logic signed [19:0] acc;
    logic [7:0]         mixed;
    diff  = $signed({2'b00, rf.p}) - $signed({2'b00, rf.t});
    acc   = $signed({1'b0, rf.alpha}) * diff + $signed({4'b0000, rf.t, 8'd0});
    mixed = acc[15:8];
    if (rf.bypass)       ro_next = rf.s;
    else if (rf.hardmix) ro_next = mixed[7] ? cbm_pkg::FULL : 8'd0;
    else                 ro_next = mixed;
  end

  always_ff @(posedge clk) begin
    if (en[0]) ra <= ra_next;
    if (en[1]) rb <= rb_next;
    if (en[2]) c1 <= rb;
    if (en[3]) c2 <= c1;
    if (en[4]) c3 <= c2;
    if (en[5]) c4 <= c3;
    if (en[6]) rf <= rf_next;
    if (en[7]) ro <= ro_next;
  end

  assign blended_value = ro;

endmodule
`default_nettype wire

>>> rtl/cbm_checker.sv
// Port-level checks for the channel blend block, bound to the top level.
`default_nettype none
module cbm_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] blended_value
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("item shown right after reset");

  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  a_drain_ready: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input stalled while output drains");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(blended_value))
    else $error("stalled item changed or dropped");

endmodule

bind channel_blend_modes cbm_checker u_cbm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .blended_value (blended_value)
);
`default_nettype wire
